FILE: src/perlin_noise_2d_octaves_defines.svh
// Assertion macros for the 2-D octave noise block.
// Used by the port checker; depends on nothing.
`ifndef PERLIN_NOISE_2D_OCTAVES_DEFINES_SVH
`define PERLIN_NOISE_2D_OCTAVES_DEFINES_SVH

// same-cycle implication
`define PN2D_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PN2D_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/pn2d_pkg.sv
// Shared types and constants for the 2-D octave noise block.
// No dependencies.
package pn2d_pkg;

  localparam int TABLE_SIZE_DEF  = 256;
  localparam int MAX_OCTAVES_DEF = 8;

  localparam int POS_W     = 32;
  localparam int FREQ_W    = 24;
  localparam int AMP_W     = 24;
  localparam int OFS_W     = 32;
  localparam int GRAD_W    = 16;
  localparam int PERM_W    = 8;
  localparam int IDX_W     = 8;
  localparam int OCT_CFG_W = 4;
  localparam int OUT_W     = 32;
  localparam int COORD_W   = POS_W + FREQ_W + 1;  // pos * freq, signed
  localparam int PADDR_W   = 4;
  localparam int PDATA_W   = 32;
  localparam int QUEUE_DEPTH = 2;
  localparam int STEP_W    = 5;

  typedef enum logic [1:0] {
    ACT_EVAL = 2'd0,
    ACT_GRAD = 2'd1,
    ACT_PERM = 2'd2
  } action_t;

  typedef enum logic [1:0] {
    REG_OCTAVES = 2'd0,
    REG_FREQ    = 2'd1,
    REG_AMP     = 2'd2,
    REG_OFFSET  = 2'd3
  } reg_index_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_OCT,
    ST_GAIN,
    ST_DONE
  } back_state_t;

  // one lattice evaluation, at most one multiply per step
  typedef enum logic [STEP_W-1:0] {
    S_COORD, S_RD_X, S_RD_H0, S_RD_H1, S_RD_G0, S_RD_G1,
    S_DOT00A, S_DOT00B, S_DOT10A, S_DOT10B, S_DOT01A, S_DOT01B,
    S_DOT11A, S_DOT11B, S_LERP_X0, S_LERP_X1, S_LERP_XB, S_LERP_Y, S_ACCUM
  } oct_step_t;

  typedef struct packed {
    action_t                    kind;
    logic signed [COORD_W-1:0]  cx;
    logic signed [COORD_W-1:0]  cy;
    logic [IDX_W-1:0]           idx;
    logic [2*GRAD_W-1:0]        grad;  // y in upper half, x in lower
    logic [PERM_W-1:0]          perm;
  } work_t;

  typedef struct packed {
    logic [OCT_CFG_W-1:0]      octaves;
    logic signed [AMP_W-1:0]   amp;
    logic signed [OFS_W-1:0]   offset;
  } back_cfg_t;

endpackage

FILE: src/pn2d_front.sv
// Front end: takes requests, drops unknown actions, scales coordinates.
// Depends on pn2d_pkg.
module pn2d_front (
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [1:0]                      action,
  input  logic signed [pn2d_pkg::POS_W-1:0] pos_x,
  input  logic signed [pn2d_pkg::POS_W-1:0] pos_y,
  input  logic [pn2d_pkg::IDX_W-1:0]      table_index,
  input  logic signed [pn2d_pkg::GRAD_W-1:0] grad_x,
  input  logic signed [pn2d_pkg::GRAD_W-1:0] grad_y,
  input  logic [pn2d_pkg::PERM_W-1:0]     perm_value,
  input  logic [pn2d_pkg::FREQ_W-1:0]     base_frequency,
  output logic                            push_valid,
  input  logic                            push_ready,
  output pn2d_pkg::work_t                 push_data
);
  import pn2d_pkg::*;

  logic known;
  logic signed [FREQ_W:0] freq_s;

  assign freq_s = $signed({1'b0, base_frequency});

  always_comb begin
    case (action_t'(action))
      ACT_EVAL, ACT_GRAD, ACT_PERM: known = 1'b1;
      default:                      known = 1'b0;
    endcase
  end

  assign in_ready   = push_ready;
  assign push_valid = in_valid && known;

  always_comb begin
    push_data.kind = action_t'(action);
    push_data.cx   = COORD_W'(pos_x) * COORD_W'(freq_s);
    push_data.cy   = COORD_W'(pos_y) * COORD_W'(freq_s);
    push_data.idx  = table_index;
    push_data.grad = {grad_y, grad_x};
    push_data.perm = perm_value;
  end

endmodule

FILE: src/pn2d_queue.sv
// Short request queue between front and back end.
// Depends on pn2d_pkg.
module pn2d_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push_valid,
  output logic            push_ready,
  input  pn2d_pkg::work_t push_data,
  output logic            pop_valid,
  input  logic            pop_ready,
  output pn2d_pkg::work_t pop_data
);
  import pn2d_pkg::*;

  localparam int QPW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [QCW-1:0] FULL = QCW'(QUEUE_DEPTH);
  localparam logic [QPW-1:0] LAST = QPW'(QUEUE_DEPTH - 1);

  work_t          slots [QUEUE_DEPTH];
  logic [QPW-1:0] wr_ptr;
  logic [QPW-1:0] rd_ptr;
  logic [QCW-1:0] count;
  logic           push_fire;
  logic           pop_fire;

  assign push_ready = (count != FULL);
  assign pop_valid  = (count != '0);
  assign pop_data   = slots[rd_ptr];
  assign push_fire  = push_valid && push_ready;
  assign pop_fire   = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (push_fire) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push_fire) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (pop_fire) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + 1'b1;
      end
      case ({push_fire, pop_fire})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

FILE: src/pn2d_back.sv
// Back end: table stores, octave sequencer with one shared multiplier,
// gain, offset, saturation and the result register. Depends on pn2d_pkg.
module pn2d_back #(
  parameter int TABLE_SIZE  = pn2d_pkg::TABLE_SIZE_DEF,
  parameter int MAX_OCTAVES = pn2d_pkg::MAX_OCTAVES_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             pop_valid,
  output logic                             pop_ready,
  input  pn2d_pkg::work_t                  pop_data,
  input  pn2d_pkg::back_cfg_t              cfg,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic signed [pn2d_pkg::OUT_W-1:0] noise_value,
  output logic                             saturated
);
  import pn2d_pkg::*;

  localparam int TW  = $clog2(TABLE_SIZE);
  localparam int OW  = $clog2(MAX_OCTAVES + 1);
  localparam int MW  = 25;        // multiplier operand width
  localparam int PW  = 2 * MW;
  localparam int DW  = 21;        // dot / lerp values
  localparam int SW  = 24;        // octave sum
  localparam int RW  = 36;        // result before clipping
  localparam int CW  = 64;        // coordinate wraps modulo 2^64
  localparam logic [MW-1:0] ONE_Q16   = MW'(65536);
  localparam logic [MW-1:0] THREE_Q16 = MW'(196608);
  localparam logic signed [RW-1:0] SAT_HI = {{(RW-OUT_W+1){1'b0}}, {(OUT_W-1){1'b1}}};
  localparam logic signed [RW-1:0] SAT_LO = {{(RW-OUT_W+1){1'b1}}, {(OUT_W-1){1'b0}}};

  // table stores
  logic [2*GRAD_W-1:0] grad_mem [TABLE_SIZE];
  logic [PERM_W-1:0]   perm_mem [TABLE_SIZE];
  logic [TW-1:0] perm_addr_a, perm_addr_b, grad_addr_a, grad_addr_b;
  logic [PERM_W-1:0]   perm_rd_a, perm_rd_b;
  logic [2*GRAD_W-1:0] grad_rd_a, grad_rd_b;

  back_state_t state, state_next;
  oct_step_t   step, step_next;

  logic pop_fire, load_grad, load_perm, start_eval, result_load;
  logic [TW-1:0] wr_addr;

  logic signed [COORD_W-1:0] cx, cy;
  logic [CW-1:0] cx_sh, cy_sh;
  logic [OW-1:0] oct_i, oct_i_inc, n_eff, n_eff_next;
  logic [OW+OCT_CFG_W-1:0] oct_ext;

  logic [TW-1:0] x0, x1, y0, y1, h00, h01, h10, h11;
  logic [PERM_W-1:0] p1;
  logic [15:0] fx, fy, f2x, f2y;
  logic [16:0] sx, sy;
  logic [2*GRAD_W-1:0] g00, g01, g10, g11;
  logic signed [PW-1:0] acc, prod, dot_sum, dot_shift, frac_shift, gain_shift;
  logic signed [DW-1:0] d00, d10, d01, d11, la, lb, oct_e, oct_e_sh;
  logic signed [SW-1:0] sum;
  logic signed [RW-1:0] res;
  logic signed [MW-1:0] mul_a, mul_b;
  logic signed [MW-1:0] fx_s, fy_s, fx1, fy1;

  function automatic logic [TW-1:0] to_index(input logic [IDX_W-1:0] v);
    logic [TW+IDX_W-1:0] ext;
    begin
      ext = {{TW{1'b0}}, v};
      return ext[TW-1:0];
    end
  endfunction

  function automatic logic [TW-1:0] hash_addr(input logic [PERM_W-1:0] p,
                                              input logic [TW-1:0] y);
    logic [TW+PERM_W-1:0] s;
    begin
      s = {{TW{1'b0}}, p} + {{PERM_W{1'b0}}, y};
      return s[TW-1:0];
    end
  endfunction

  function automatic logic signed [MW-1:0] gx_of(input logic [2*GRAD_W-1:0] g);
    return {{(MW-GRAD_W){g[GRAD_W-1]}}, g[GRAD_W-1:0]};
  endfunction

  function automatic logic signed [MW-1:0] gy_of(input logic [2*GRAD_W-1:0] g);
    return {{(MW-GRAD_W){g[2*GRAD_W-1]}}, g[2*GRAD_W-1:GRAD_W]};
  endfunction

  function automatic logic signed [MW-1:0] ext_d(input logic signed [DW-1:0] v);
    return {{(MW-DW){v[DW-1]}}, v};
  endfunction

  assign pop_ready  = (state == ST_IDLE);
  assign pop_fire   = pop_valid && pop_ready;
  assign load_grad  = pop_fire && (pop_data.kind == ACT_GRAD);
  assign load_perm  = pop_fire && (pop_data.kind == ACT_PERM);
  assign start_eval = pop_fire && (pop_data.kind == ACT_EVAL);
  assign wr_addr    = to_index(pop_data.idx);

  assign oct_ext    = {{OW{1'b0}}, cfg.octaves};
  assign n_eff_next = (int'(cfg.octaves) > MAX_OCTAVES) ? OW'(MAX_OCTAVES)
                                                        : oct_ext[OW-1:0];
  assign oct_i_inc  = oct_i + 1'b1;

  assign cx_sh = {{(CW-COORD_W){cx[COORD_W-1]}}, cx} << oct_i;
  assign cy_sh = {{(CW-COORD_W){cy[COORD_W-1]}}, cy} << oct_i;

  assign fx_s = {{(MW-16){1'b0}}, fx};
  assign fy_s = {{(MW-16){1'b0}}, fy};
  assign fx1  = fx_s - ONE_Q16;
  assign fy1  = fy_s - ONE_Q16;

  assign dot_sum    = acc + prod;
  assign dot_shift  = dot_sum >>> 14;
  assign frac_shift = prod >>> 16;
  assign gain_shift = prod >>> 16;
  assign oct_e      = la + frac_shift[DW-1:0];
  assign oct_e_sh   = oct_e >>> oct_i;
  assign res        = $signed(gain_shift[RW-1:0])
                    + {{(RW-OFS_W){cfg.offset[OFS_W-1]}}, cfg.offset};

  // store read addresses
  always_comb begin
    perm_addr_a = x0;
    perm_addr_b = x1;
    grad_addr_a = h00;
    grad_addr_b = h01;
    case (step)
      S_RD_H0: begin
        perm_addr_a = hash_addr(perm_rd_a, y0);
        perm_addr_b = hash_addr(perm_rd_a, y1);
      end
      S_RD_H1: begin
        perm_addr_a = hash_addr(p1, y0);
        perm_addr_b = hash_addr(p1, y1);
      end
      S_RD_G1: begin
        grad_addr_a = h10;
        grad_addr_b = h11;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (load_grad) begin
      grad_mem[wr_addr] <= pop_data.grad;
    end
    if (load_perm) begin
      perm_mem[wr_addr] <= pop_data.perm;
    end
    perm_rd_a <= perm_mem[perm_addr_a];
    perm_rd_b <= perm_mem[perm_addr_b];
    grad_rd_a <= grad_mem[grad_addr_a];
    grad_rd_b <= grad_mem[grad_addr_b];
  end

  // shared multiplier operand select
  always_comb begin
    mul_a = {{(MW-SW){sum[SW-1]}}, sum};
    mul_b = {cfg.amp[AMP_W-1], cfg.amp};
    if (state == ST_OCT) begin
      case (step)
        S_RD_X:    begin mul_a = fx_s; mul_b = fx_s; end
        S_RD_H0:   begin mul_a = fy_s; mul_b = fy_s; end
        S_RD_H1: begin
          mul_a = {{(MW-16){1'b0}}, f2x};
          mul_b = THREE_Q16 - {{(MW-17){1'b0}}, fx, 1'b0};
        end
        S_RD_G0: begin
          mul_a = {{(MW-16){1'b0}}, f2y};
          mul_b = THREE_Q16 - {{(MW-17){1'b0}}, fy, 1'b0};
        end
        S_DOT00A:  begin mul_a = gx_of(g00); mul_b = fx_s; end
        S_DOT00B:  begin mul_a = gy_of(g00); mul_b = fy_s; end
        S_DOT10A:  begin mul_a = gx_of(g10); mul_b = fx1;  end
        S_DOT10B:  begin mul_a = gy_of(g10); mul_b = fy_s; end
        S_DOT01A:  begin mul_a = gx_of(g01); mul_b = fx_s; end
        S_DOT01B:  begin mul_a = gy_of(g01); mul_b = fy1;  end
        S_DOT11A:  begin mul_a = gx_of(g11); mul_b = fx1;  end
        S_DOT11B:  begin mul_a = gy_of(g11); mul_b = fy1;  end
        S_LERP_X0: begin
          mul_a = ext_d(d10) - ext_d(d00);
          mul_b = {{(MW-17){1'b0}}, sx};
        end
        S_LERP_X1: begin
          mul_a = ext_d(d11) - ext_d(d01);
          mul_b = {{(MW-17){1'b0}}, sx};
        end
        S_LERP_Y: begin
          mul_a = ext_d(lb) - ext_d(la);
          mul_b = {{(MW-17){1'b0}}, sy};
        end
        default: begin
          mul_a = '0;
          mul_b = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  // sequencer
  always_comb begin
    state_next  = state;
    step_next   = step;
    result_load = 1'b0;
    case (state)
      ST_IDLE: begin
        step_next = S_COORD;
        if (start_eval) begin
          state_next = (n_eff_next == '0) ? ST_GAIN : ST_OCT;
        end
      end
      ST_OCT: begin
        if (step == S_ACCUM) begin
          step_next = S_COORD;
          if (oct_i_inc == n_eff) begin
            state_next = ST_GAIN;
          end
        end else begin
          step_next = oct_step_t'(STEP_W'(step + 1'b1));
        end
      end
      ST_GAIN: state_next = ST_DONE;
      ST_DONE: begin
        if (!out_valid || out_ready) begin
          result_load = 1'b1;
          state_next  = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      step      <= S_COORD;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      step  <= step_next;
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (result_load) begin
        out_valid <= 1'b1;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start_eval) begin
      cx    <= pop_data.cx;
      cy    <= pop_data.cy;
      oct_i <= '0;
      n_eff <= n_eff_next;
      sum   <= '0;
    end
    if (state == ST_OCT) begin
      case (step)
        S_COORD: begin
          x0 <= cx_sh[32 +: TW];
          x1 <= cx_sh[32 +: TW] + 1'b1;
          y0 <= cy_sh[32 +: TW];
          y1 <= cy_sh[32 +: TW] + 1'b1;
          fx <= cx_sh[31:16];
          fy <= cy_sh[31:16];
        end
        S_RD_H0: begin
          p1  <= perm_rd_b;
          f2x <= prod[31:16];
        end
        S_RD_H1: begin
          h00 <= to_index(perm_rd_a);
          h01 <= to_index(perm_rd_b);
          f2y <= prod[31:16];
        end
        S_RD_G0: begin
          h10 <= to_index(perm_rd_a);
          h11 <= to_index(perm_rd_b);
          sx  <= prod[32:16];
        end
        S_RD_G1: begin
          g00 <= grad_rd_a;
          g01 <= grad_rd_b;
          sy  <= prod[32:16];
        end
        S_DOT00A: begin
          g10 <= grad_rd_a;
          g11 <= grad_rd_b;
        end
        S_DOT00B, S_DOT10B, S_DOT01B, S_DOT11B: acc <= prod;
        S_DOT10A:  d00 <= dot_shift[DW-1:0];
        S_DOT01A:  d10 <= dot_shift[DW-1:0];
        S_DOT11A:  d01 <= dot_shift[DW-1:0];
        S_LERP_X0: d11 <= dot_shift[DW-1:0];
        S_LERP_X1: la  <= d00 + frac_shift[DW-1:0];
        S_LERP_XB: lb  <= d01 + frac_shift[DW-1:0];
        S_ACCUM: begin
          sum   <= sum + {{(SW-DW){oct_e_sh[DW-1]}}, oct_e_sh};
          oct_i <= oct_i_inc;
        end
        default: begin
        end
      endcase
    end
    if (result_load) begin
      if (res > SAT_HI) begin
        noise_value <= SAT_HI[OUT_W-1:0];
        saturated   <= 1'b1;
      end else if (res < SAT_LO) begin
        noise_value <= SAT_LO[OUT_W-1:0];
        saturated   <= 1'b1;
      end else begin
        noise_value <= res[OUT_W-1:0];
        saturated   <= 1'b0;
      end
    end
  end

endmodule

FILE: src/perlin_noise_2d_octaves.sv
// 2-D gradient noise summed over octaves, Q16.16 in and out.
// Load requests (action 1, 2) fill the gradient and permutation stores; an
// evaluate request (action 0) returns one result, loads return none, and
// action 3 is dropped. Requests pass a front end (coordinate scaling by
// base_frequency) and a two-entry queue into a back end that runs one
// request at a time. A load is written into its store as the back end takes
// it; an evaluate runs the lattice steps once per octave, then gain, offset
// and clipping. The evaluate time is set by the single shared 25x25
// multiplier that handles smoothstep, the eight dot-product terms and the
// three blends in turn, and by the two read ports of each table store.
// The front end keeps taking requests while the queue has room, and a
// finished result waits in the output register.
// Stores are not cleared by reset: read only entries that were written.
// Registers (APB, byte address 4*i): 0 octave_count, 1 base_frequency,
// 2 output_amplitude, 3 output_offset. Depends on pn2d_pkg, pn2d_front,
// pn2d_queue, pn2d_back.
module perlin_noise_2d_octaves #(
  parameter int TABLE_SIZE  = pn2d_pkg::TABLE_SIZE_DEF,  // power of two, 16..4096
  parameter int MAX_OCTAVES = pn2d_pkg::MAX_OCTAVES_DEF  // 1..16
) (
  input  logic                                clk,
  input  logic                                rst,
  // request channel
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [1:0]                          action,
  input  logic signed [pn2d_pkg::POS_W-1:0]   pos_x,
  input  logic signed [pn2d_pkg::POS_W-1:0]   pos_y,
  input  logic [pn2d_pkg::IDX_W-1:0]          table_index,
  input  logic signed [pn2d_pkg::GRAD_W-1:0]  grad_x,
  input  logic signed [pn2d_pkg::GRAD_W-1:0]  grad_y,
  input  logic [pn2d_pkg::PERM_W-1:0]         perm_value,
  // result channel
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [pn2d_pkg::OUT_W-1:0]   noise_value,
  output logic                                saturated,
  // config port
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [pn2d_pkg::PADDR_W-1:0]        paddr,
  input  logic [pn2d_pkg::PDATA_W-1:0]        pwdata,
  output logic [pn2d_pkg::PDATA_W-1:0]        prdata,
  output logic                                pready
);
  import pn2d_pkg::*;

  // config registers
  logic [OCT_CFG_W-1:0]    octave_count;
  logic [FREQ_W-1:0]       base_frequency;
  logic signed [AMP_W-1:0] output_amplitude;
  logic signed [OFS_W-1:0] output_offset;
  logic                    cfg_write;
  reg_index_t              cfg_sel;
  back_cfg_t               back_cfg;

  // front -> queue -> back
  logic  push_valid, push_ready, pop_valid, pop_ready;
  work_t push_data, pop_data;

  assign pready    = 1'b1;
  assign cfg_sel   = reg_index_t'(paddr[3:2]);
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      octave_count     <= OCT_CFG_W'(1);
      base_frequency   <= FREQ_W'(65536);
      output_amplitude <= AMP_W'(65536);
      output_offset    <= '0;
    end else if (cfg_write) begin
      case (cfg_sel)
        REG_OCTAVES: octave_count     <= pwdata[OCT_CFG_W-1:0];
        REG_FREQ:    base_frequency   <= pwdata[FREQ_W-1:0];
        REG_AMP:     output_amplitude <= pwdata[AMP_W-1:0];
        REG_OFFSET:  output_offset    <= pwdata[OFS_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // readback; amplitude comes back sign extended
  always_comb begin
    case (cfg_sel)
      REG_OCTAVES: prdata = {{(PDATA_W-OCT_CFG_W){1'b0}}, octave_count};
      REG_FREQ:    prdata = {{(PDATA_W-FREQ_W){1'b0}}, base_frequency};
      REG_AMP:     prdata = {{(PDATA_W-AMP_W){output_amplitude[AMP_W-1]}},
                             output_amplitude};
      REG_OFFSET:  prdata = output_offset;
      default:     prdata = '0;
    endcase
  end

  always_comb begin
    back_cfg.octaves = octave_count;
    back_cfg.amp     = output_amplitude;
    back_cfg.offset  = output_offset;
  end

  pn2d_front u_front (
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .action         (action),
    .pos_x          (pos_x),
    .pos_y          (pos_y),
    .table_index    (table_index),
    .grad_x         (grad_x),
    .grad_y         (grad_y),
    .perm_value     (perm_value),
    .base_frequency (base_frequency),
    .push_valid     (push_valid),
    .push_ready     (push_ready),
    .push_data      (push_data)
  );

  pn2d_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  pn2d_back #(
    .TABLE_SIZE  (TABLE_SIZE),
    .MAX_OCTAVES (MAX_OCTAVES)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .pop_valid   (pop_valid),
    .pop_ready   (pop_ready),
    .pop_data    (pop_data),
    .cfg         (back_cfg),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .noise_value (noise_value),
    .saturated   (saturated)
  );

endmodule

FILE: src/pn2d_checker.sv
// Port-level checks for the 2-D octave noise block, bound to the top.
// Depends on perlin_noise_2d_octaves_defines.svh.
`include "perlin_noise_2d_octaves_defines.svh"

module pn2d_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic [1:0]  action,
  input logic [31:0] pos_x,
  input logic [31:0] pos_y,
  input logic [7:0]  table_index,
  input logic [15:0] grad_x,
  input logic [15:0] grad_y,
  input logic [7:0]  perm_value,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] noise_value,
  input logic        saturated,
  input logic        psel,
  input logic        penable,
  input logic        pwrite,
  input logic [3:0]  paddr,
  input logic [31:0] pwdata,
  input logic [31:0] prdata,
  input logic        pready
);

  // a stalled result keeps its value
  `PN2D_ASSERT_NXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(noise_value) && $stable(saturated), "stalled result changed")

  // a clipped result sits at one of the range ends
  `PN2D_ASSERT_IMP(a_sat_clip, clk, rst, out_valid && saturated, noise_value == 32'h7FFFFFFF || noise_value == 32'h80000000, "saturated flag without clipped value")

  // no result right after reset
  `PN2D_ASSERT_NXT(a_reset_quiet, clk, 1'b0, rst, !out_valid, "result valid after reset")

endmodule

bind perlin_noise_2d_octaves pn2d_checker u_pn2d_checker (.*);
